// ===== hw/rtl/art_pkg.sv =====
// Shared types and constants for the address region table.
package art_pkg;

  // Table geometry.
  localparam int MAX_REGIONS = 16;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  // Field widths of the beats.
  localparam int TYPE_W = 4;
  localparam int BUS_W  = 8;
  localparam int ADDR_W = 32;
  localparam int INIDX_W = 4;
  localparam int EIU_W  = 5;
  localparam int ST_W   = 2;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_EIU_ADDR = 3'd0;
  localparam logic [EIU_W-1:0]   EIU_RESET    = 5'd16;

  // Operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERLAP = 2'd2;

  // One stored region.
  typedef struct packed {
    logic [TYPE_W-1:0] typ;
    logic [BUS_W-1:0]  bus;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
  } entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN
  } state_t;

  // Kind of result beat to build.
  typedef enum logic [2:0] {
    RK_OK,
    RK_RANGE,
    RK_OVERLAP,
    RK_HIT,
    RK_MISS
  } res_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      cnt_clr;
    logic      issue;
    logic      commit;
    logic      emit;
    res_kind_t kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_write;
    logic idx_oob;
    logic type_zero;
    logic scan_more;
    logic pend;
    logic match;
  } stat_t;

endpackage

// ===== hw/rtl/art_ctrl.sv =====
// Controller state machine of the address region table.
module art_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  art_pkg::stat_t  stat,
  output art_pkg::cmd_t   cmd
);

  art_pkg::state_t state_r;
  art_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= art_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.kind    = art_pkg::RK_OK;
    busy        = (state_r != art_pkg::S_IDLE);
    unique case (state_r)
      art_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = art_pkg::S_CHECK;
        end
      end
      art_pkg::S_CHECK: begin
        // Refused and unchecked writes finish here; the rest walk the table.
        if (stat.is_write && stat.idx_oob) begin
          cmd.emit  = 1'b1;
          cmd.kind  = art_pkg::RK_RANGE;
          state_nxt = art_pkg::S_IDLE;
        end else if (stat.is_write && stat.type_zero) begin
          cmd.commit = 1'b1;
          cmd.emit   = 1'b1;
          cmd.kind   = art_pkg::RK_OK;
          state_nxt  = art_pkg::S_IDLE;
        end else begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = art_pkg::S_SCAN;
        end
      end
      art_pkg::S_SCAN: begin
        cmd.issue = stat.scan_more;
        if (stat.pend && stat.match) begin
          cmd.emit  = 1'b1;
          cmd.kind  = stat.is_write ? art_pkg::RK_OVERLAP : art_pkg::RK_HIT;
          state_nxt = art_pkg::S_IDLE;
        end else if (!stat.scan_more) begin
          // Nothing left to read and the last entry read did not match.
          cmd.emit   = 1'b1;
          cmd.commit = stat.is_write;
          cmd.kind   = stat.is_write ? art_pkg::RK_OK : art_pkg::RK_MISS;
          state_nxt  = art_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = art_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Every result beat ends the item.
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == art_pkg::S_IDLE))
    else $error("controller did not return to idle after a result");

  // The table is written only as part of a result beat.
  a_commit_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> cmd.emit)
    else $error("table written without a result");

  // An accepted item always moves to the check step.
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == art_pkg::S_CHECK))
    else $error("accepted item did not reach the check step");

  // No new item is taken while one is in flight.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == art_pkg::S_IDLE))
    else $error("item loaded while busy");
`endif

endmodule

// ===== hw/rtl/art_datapath.sv =====
// Datapath of the address region table: region memory, scan counter and result registers.
module art_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  art_pkg::cmd_t                         cmd,
  output art_pkg::stat_t                        stat,
  input  logic [art_pkg::CNT_W-1:0]             used_n,
  input  logic                                  in_op,
  input  logic [art_pkg::INIDX_W-1:0]           in_index,
  input  logic [art_pkg::TYPE_W-1:0]            in_region_type,
  input  logic [art_pkg::BUS_W-1:0]             in_bus_size,
  input  logic [art_pkg::ADDR_W-1:0]            in_base_addr,
  input  logic [art_pkg::ADDR_W-1:0]            in_region_length,
  input  logic [art_pkg::ADDR_W-1:0]            in_address,
  output logic                                  out_valid,
  output logic [art_pkg::ST_W-1:0]              out_status,
  output logic                                  out_hit,
  output logic [art_pkg::INIDX_W-1:0]           out_hit_index,
  output logic [art_pkg::TYPE_W-1:0]            out_hit_type,
  output logic [art_pkg::BUS_W-1:0]             out_hit_bus_size,
  output logic [art_pkg::ADDR_W-1:0]            out_hit_base,
  output logic [art_pkg::ADDR_W-1:0]            out_hit_length
);

  localparam int IW = art_pkg::IDX_W;
  localparam int CW = art_pkg::CNT_W;
  localparam int AW = art_pkg::ADDR_W;

  // Latched item.
  logic                         op_r;
  logic [art_pkg::INIDX_W-1:0]  idx_r;
  art_pkg::entry_t              new_r;
  logic [AW-1:0]                addr_r;

  // Region memory with per-entry valid bits; an invalid entry reads as zero.
  art_pkg::entry_t              mem [art_pkg::MAX_REGIONS];
  logic [art_pkg::MAX_REGIONS-1:0] valid_r;
  art_pkg::entry_t              rd_data_r;
  logic                         rd_vld_r;

  // Scan counter and read-in-flight tag.
  logic [CW-1:0]                cnt_r;
  logic                         pend_r;
  logic [IW-1:0]                pend_idx_r;

  // Result registers.
  logic                         out_valid_r;
  logic [art_pkg::ST_W-1:0]     out_status_r;
  logic                         out_hit_r;
  logic [art_pkg::INIDX_W-1:0]  out_hit_index_r;
  art_pkg::entry_t              out_entry_r;

  art_pkg::entry_t              ent;
  logic                         skip;
  logic                         collide;
  logic                         holds;
  logic [AW-1:0]                ent_end;
  logic [AW-1:0]                new_end;
  logic [AW-1:0]                addr_off;
  logic [AW-1:0]                lim;
  logic [IW-1:0]                wr_idx;

  assign wr_idx = IW'(idx_r);

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_op;
      idx_r      <= in_index;
      new_r.typ  <= in_region_type;
      new_r.bus  <= in_bus_size;
      new_r.base <= in_base_addr;
      new_r.len  <= in_region_length;
      addr_r     <= in_address;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[wr_idx] <= new_r;
    end
    rd_data_r <= mem[cnt_r[IW-1:0]];
  end

  // Valid bits, scan counter and read tag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.issue) begin
        cnt_r <= cnt_r + CW'(1);
      end
      pend_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r   <= valid_r[cnt_r[IW-1:0]];
    pend_idx_r <= cnt_r[IW-1:0];
  end

  // Overlap and containment tests on the entry just read.
  always_comb begin
    ent      = rd_vld_r ? rd_data_r : '0;
    skip     = (pend_idx_r == wr_idx) || (ent.typ == '0);
    ent_end  = ent.base + (ent.len - AW'(1));
    new_end  = new_r.base + (new_r.len - AW'(1));
    collide  = (ent.base <= new_r.base) ? (ent_end >= new_r.base) : (new_end >= ent.base);
    addr_off = addr_r - ent.base;
    lim      = ent.base + ent.len;
    if (addr_r < ent.base) begin
      holds = 1'b0;
    end else if (ent.base[AW-1]) begin
      holds = addr_off < ent.len;
    end else begin
      holds = addr_r < lim;
    end
  end

  assign stat.is_write  = (op_r == art_pkg::OP_WRITE);
  assign stat.idx_oob   = (CW'(idx_r) >= used_n);
  assign stat.type_zero = (new_r.typ == '0);
  assign stat.scan_more = (cnt_r < used_n);
  assign stat.pend      = pend_r;
  assign stat.match     = stat.is_write ? (!skip && collide) : holds;

  // Result beat strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r    <= art_pkg::ST_OK;
      out_hit_r       <= 1'b0;
      out_hit_index_r <= '0;
      out_entry_r     <= '0;
      unique case (cmd.kind)
        art_pkg::RK_RANGE:   out_status_r <= art_pkg::ST_RANGE;
        art_pkg::RK_OVERLAP: out_status_r <= art_pkg::ST_OVERLAP;
        art_pkg::RK_HIT: begin
          out_hit_r       <= 1'b1;
          out_hit_index_r <= art_pkg::INIDX_W'(pend_idx_r);
          out_entry_r     <= ent;
        end
        art_pkg::RK_OK, art_pkg::RK_MISS: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_hit          = out_hit_r;
  assign out_hit_index    = out_hit_index_r;
  assign out_hit_type     = out_entry_r.typ;
  assign out_hit_bus_size = out_entry_r.bus;
  assign out_hit_base     = out_entry_r.base;
  assign out_hit_length   = out_entry_r.len;

`ifndef SYNTHESIS
  // A read tag is only live in the cycle after a read was issued.
  a_pend_issue: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(cmd.issue))
    else $error("read tag live without an issued read");

  // A committed entry reads back as valid.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> valid_r[$past(wr_idx)])
    else $error("committed entry not marked valid");

  // The scan never reads beyond the entries in use.
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (cnt_r < used_n))
    else $error("scan read past the entries in use");
`endif

endmodule

// ===== hw/rtl/address_region_table.sv =====
// Top level of the address region table: configuration register and module wiring.
//
// A table of up to 16 address regions. Pulse start while busy is low to hand in one
// beat: a write stores a region (refused when the index is at or beyond the entries
// in use, or when a used type overlaps another used region), a lookup returns the
// first entry in index order holding the address. Each item gives exactly one result
// beat, shown for one cycle with out_valid high; the receiver cannot stall it, so it
// must take every beat. A refused or type-zero write answers from the check step; a
// checked write or a lookup walks the table through the region memory's single read
// port, one entry a cycle, and answers once every entry in use has been read, earlier
// on a match. busy stays high until the result beat is built. The table resets to all
// zeros at once through per-entry valid bits, with no clearing pass. entries_in_use sits
// at byte address 0 of the configuration port; the user must write it only while the
// block idles, and the block itself does not enforce it.
module address_region_table (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [art_pkg::PADDR_W-1:0]           paddr,
  input  logic [art_pkg::PDATA_W-1:0]           pwdata,
  output logic [art_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready,
  // Input channel.
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_op,
  input  logic [art_pkg::INIDX_W-1:0]           in_index,
  input  logic [art_pkg::TYPE_W-1:0]            in_region_type,
  input  logic [art_pkg::BUS_W-1:0]             in_bus_size,
  input  logic [art_pkg::ADDR_W-1:0]            in_base_addr,
  input  logic [art_pkg::ADDR_W-1:0]            in_region_length,
  input  logic [art_pkg::ADDR_W-1:0]            in_address,
  // Result channel.
  output logic                                  out_valid,
  output logic [art_pkg::ST_W-1:0]              out_status,
  output logic                                  out_hit,
  output logic [art_pkg::INIDX_W-1:0]           out_hit_index,
  output logic [art_pkg::TYPE_W-1:0]            out_hit_type,
  output logic [art_pkg::BUS_W-1:0]             out_hit_bus_size,
  output logic [art_pkg::ADDR_W-1:0]            out_hit_base,
  output logic [art_pkg::ADDR_W-1:0]            out_hit_length
);

  logic [art_pkg::EIU_W-1:0] eiu_r;
  logic [art_pkg::CNT_W-1:0] used_n;
  logic                      cfg_wr;
  art_pkg::cmd_t             cmd;
  art_pkg::stat_t            stat;

  // Configuration register write.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == art_pkg::REG_EIU_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eiu_r <= art_pkg::EIU_RESET;
    end else if (cfg_wr) begin
      eiu_r <= pwdata[art_pkg::EIU_W-1:0];
    end
  end

  // Register read.
  assign prdata = (paddr == art_pkg::REG_EIU_ADDR) ?
                  art_pkg::PDATA_W'(eiu_r) : '0;

  // Entries in use, saturated at the table depth.
  assign used_n = (art_pkg::CNT_W'(eiu_r) > art_pkg::CNT_W'(art_pkg::MAX_REGIONS)) ?
                  art_pkg::CNT_W'(art_pkg::MAX_REGIONS) : art_pkg::CNT_W'(eiu_r);

  art_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  art_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .used_n           (used_n),
    .in_op            (in_op),
    .in_index         (in_index),
    .in_region_type   (in_region_type),
    .in_bus_size      (in_bus_size),
    .in_base_addr     (in_base_addr),
    .in_region_length (in_region_length),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_hit          (out_hit),
    .out_hit_index    (out_hit_index),
    .out_hit_type     (out_hit_type),
    .out_hit_bus_size (out_hit_bus_size),
    .out_hit_base     (out_hit_base),
    .out_hit_length   (out_hit_length)
  );

endmodule
